// ----- src/assert_macros.svh -----
// Assertion macros shared by the merge block's RTL files.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define KWM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kwm assertion failed");

// Same-cycle implication.
`define KWM_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kwm assertion failed");

// Next-cycle implication.
`define KWM_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kwm assertion failed");

`endif

// ----- src/kwm_pkg.sv -----
// Shared types and constants of the k-way sorted list merge block.
// No dependencies; used by the front, back and top-level modules.
package kwm_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 3;

  typedef struct packed {
    logic [INDEX_W-1:0]        list_index;
    logic signed [VALUE_W-1:0] value;
    logic                      carries_value;
    logic                      end_of_load;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic                      last_of_run;
    logic                      nothing_loaded;
    logic                      overflow;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [INDEX_W-1:0]        list_index;
    logic signed [VALUE_W-1:0] value;
    logic                      store;
    logic                      eol;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_SCAN,
    B_EMIT,
    B_FETCH
  } back_state_t;

endpackage

// ----- src/kwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/kwm_front.sv -----
// Front end of the merge block: accepts input items, classifies them and
// queues commands for the back end. Depends on kwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kwm_front #(
  parameter int unsigned LIST_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  kwm_pkg::in_item_t item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output kwm_pkg::cmd_t    cmd
);
  import kwm_pkg::*;

  // Two-entry command queue.
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  cmd_t classified;
  logic useful;
  logic push;
  logic pop;

  // An element for a list that does not exist is ignored outright.
  always_comb begin
    classified.list_index = item.list_index;
    classified.value      = item.value;
    classified.store      = item.carries_value && (32'(item.list_index) < LIST_COUNT);
    classified.eol        = item.end_of_load;
  end

  assign useful     = classified.store || classified.eol;
  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready && useful;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = slots[rd_ptr];
  assign pop        = cmd_valid && cmd_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  `KWM_ASSERT(a_fifo_bound, count <= 2'd2)
  `KWM_ASSERT(a_ptrs_match, ((count == 2'd0) || (count == 2'd2)) == (wr_ptr == rd_ptr))

endmodule

// ----- src/kwm_back.sv -----
// Back end of the merge block: stores elements, then merges the lists by
// scanning the list heads. Depends on kwm_pkg, kwm_ram and assert_macros.svh.
`include "assert_macros.svh"

module kwm_back #(
  parameter int unsigned LIST_COUNT = 8,
  parameter int unsigned LIST_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  kwm_pkg::cmd_t      cmd,
  output logic               result_valid,
  input  logic               result_ready,
  output kwm_pkg::out_item_t result
);
  import kwm_pkg::*;

  localparam int unsigned LW = $clog2(LIST_COUNT);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned NE = LIST_COUNT * LIST_DEPTH;
  localparam int unsigned AW = $clog2(NE);
  localparam int unsigned TW = $clog2(NE + 1);

  back_state_t state;
  back_state_t state_next;

  logic [CW-1:0]      fill [LIST_COUNT];
  logic [CW-1:0]      pos  [LIST_COUNT];
  logic [VALUE_W-1:0] head [LIST_COUNT];
  logic               ovf;
  logic [TW-1:0]      remaining;
  logic [LW-1:0]      scan_k;
  logic [LW-1:0]      best;
  logic [VALUE_W-1:0] best_val;
  logic               found;

  logic [LW-1:0]      cur;
  logic [CW-1:0]      fill_cur;
  logic [CW-1:0]      pos_cur;
  logic [VALUE_W-1:0] head_cur;
  logic               out_free;
  logic               cand;
  logic               do_store;
  logic               list_full;
  logic               emit;
  logic               emit_empty;
  logic               clear_all;
  logic               more_in_list;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // One list is addressed at a time; the state decides which.
  always_comb begin
    case (state)
      B_IDLE:  cur = LW'(cmd.list_index);
      B_SCAN:  cur = scan_k;
      default: cur = best;
    endcase
  end

  assign fill_cur     = fill[cur];
  assign pos_cur      = pos[cur];
  assign head_cur     = head[cur];
  assign out_free     = !result_valid || result_ready;
  assign list_full    = (fill_cur == CW'(LIST_DEPTH));
  assign more_in_list = ((pos_cur + CW'(1)) != fill_cur);
  assign ram_waddr    = AW'(cur) * AW'(LIST_DEPTH) + AW'(fill_cur);
  assign ram_raddr    = AW'(cur) * AW'(LIST_DEPTH) + AW'(pos_cur + CW'(1));
  assign cand         = (pos_cur != fill_cur) &&
                        (!found || ($signed(head_cur) < $signed(best_val)));

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    do_store   = 1'b0;
    ram_we     = 1'b0;
    emit       = 1'b0;
    emit_empty = 1'b0;
    clear_all  = 1'b0;
    case (state)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          do_store = cmd.store;
          ram_we   = cmd.store && !list_full;
          if (cmd.eol) begin
            state_next = B_CHECK;
          end
        end
      end
      B_CHECK: begin
        if (remaining == '0) begin
          if (out_free) begin
            emit_empty = 1'b1;
            clear_all  = 1'b1;
            state_next = B_IDLE;
          end
        end else begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_k == LW'(LIST_COUNT - 1)) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (more_in_list) begin
            state_next = B_FETCH;
          end else if (remaining == TW'(1)) begin
            clear_all  = 1'b1;
            state_next = B_IDLE;
          end else begin
            state_next = B_SCAN;
          end
        end
      end
      B_FETCH: begin
        state_next = B_SCAN;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        fill[i] <= '0;
        pos[i]  <= '0;
      end
      ovf          <= 1'b0;
      remaining    <= '0;
      found        <= 1'b0;
      scan_k       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit || emit_empty) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (do_store) begin
        if (list_full) begin
          ovf <= 1'b1;
        end else begin
          fill[cur] <= fill_cur + CW'(1);
          remaining <= remaining + TW'(1);
        end
      end

      if (state_next == B_SCAN && state != B_SCAN) begin
        scan_k <= '0;
        found  <= 1'b0;
      end else if (state == B_SCAN) begin
        scan_k <= scan_k + LW'(1);
        if (cand) begin
          found <= 1'b1;
        end
      end

      // The last result of a run also empties every list.
      if (clear_all) begin
        for (int i = 0; i < LIST_COUNT; i++) begin
          fill[i] <= '0;
          pos[i]  <= '0;
        end
        ovf       <= 1'b0;
        remaining <= '0;
      end else if (emit) begin
        pos[cur]  <= pos_cur + CW'(1);
        remaining <= remaining - TW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (do_store && !list_full && fill_cur == '0) begin
      head[cur] <= cmd.value;
    end
    if (state == B_FETCH) begin
      head[cur] <= ram_rdata;
    end
    if (state == B_SCAN && cand) begin
      best     <= scan_k;
      best_val <= head_cur;
    end
    if (emit) begin
      result.merged_value   <= best_val;
      result.last_of_run    <= (remaining == TW'(1));
      result.nothing_loaded <= 1'b0;
      result.overflow       <= ovf;
    end else if (emit_empty) begin
      result.merged_value   <= '0;
      result.last_of_run    <= 1'b1;
      result.nothing_loaded <= 1'b1;
      result.overflow       <= ovf;
    end
  end

  kwm_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(NE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `KWM_ASSERT(a_scan_nonempty, (state != B_SCAN) || (remaining != '0))
  `KWM_IMPLY(a_emit_has_pick, state == B_EMIT, found)
  `KWM_NEXT(a_last_ends_run, emit && (remaining == TW'(1)),
            (state == B_IDLE) && (remaining == '0))

endmodule

// ----- src/k_way_sorted_list_merge.sv -----
// Top level of the k-way sorted list merge block.
// Depends on kwm_pkg, kwm_front and kwm_back (which holds kwm_ram).
//
// Usage: items arrive on the item channel (item_valid / item_ready / item).
// Each transfer may carry an element for one list, selected by list_index;
// elements go to the end of that list, and elements past LIST_DEPTH are
// dropped and raise the overflow flag for the next run. A transfer with
// end_of_load set (after storing its own element, if any) starts the merge:
// every stored value leaves on the result channel, smallest signed head
// first and the lower list index winning ties; the last has last_of_run set.
// If nothing was stored, a single result with nothing_loaded set is sent.
// After the run all lists and the overflow flag are cleared.
//
// Timing: the front queue takes one item a cycle until its two entries fill;
// the back end stores one element per cycle when idle. During the merge each
// result takes a scan of the list heads, a hand-over and, when the winning
// list has a next element, a fetch of that element from the element RAM.
// The scan over the list heads sets the merge rate.
// Results sit in an output register; while the receiver holds result_ready
// low, the merge waits; the front still accepts items until its queue fills.
// Reset is synchronous and leaves all lists empty with no result pending.
module k_way_sorted_list_merge #(
  parameter int unsigned LIST_COUNT = 8,
  parameter int unsigned LIST_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  kwm_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output kwm_pkg::out_item_t result
);
  import kwm_pkg::*;

  // Commands between the front queue and the back end.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  kwm_front #(
    .LIST_COUNT(LIST_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  kwm_back #(
    .LIST_COUNT(LIST_COUNT),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// ----- bench/tb_k_way_sorted_list_merge.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for k_way_sorted_list_merge: loads lists, checks merged runs.
// Depends on kwm_pkg and the block's RTL; keeps its own merge predictor and result queue.
module tb_k_way_sorted_list_merge;
  import kwm_pkg::*;

  localparam int unsigned LIST_COUNT = 8;
  localparam int unsigned LIST_DEPTH = 8;
  // A run of LIST_COUNT * LIST_DEPTH results, each stretched by a mostly idle
  // receiver, fits within this bound many times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4 * LIST_COUNT + 16;
  localparam int unsigned ITEMS_PER_PHASE = 45;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  logic      clk;
  logic      rst;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  k_way_sorted_list_merge #(
    .LIST_COUNT(LIST_COUNT),
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Items waiting to be driven, and merged results the predictor says are still due.
  in_item_t  item_backlog[$];
  out_item_t merged_expect[$];

  // Predictor state: the per-list stores, their fill levels and the sticky drop flag.
  logic signed [31:0] list_data[LIST_COUNT][LIST_DEPTH];
  int unsigned        list_fill[LIST_COUNT];
  bit                 list_overflowed;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          item_taken = 1'b0;
  int unsigned stim_items = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked;
  int unsigned runs_seen;
  int unsigned empty_runs;
  int unsigned overflow_runs;
  int unsigned items_accepted;

  // Applies one accepted item to the predictor. An end-of-load item merges every
  // stored list, smallest head first, lower list index first on equal values.
  task automatic absorb_item(input in_item_t it);
    int unsigned read_pos[LIST_COUNT];
    int unsigned total;
    int          best;
    logic signed [31:0] best_val;
    out_item_t   r;
    if (it.carries_value && it.list_index < LIST_COUNT) begin
      if (list_fill[it.list_index] >= LIST_DEPTH) begin
        list_overflowed = 1'b1;
      end else begin
        list_data[it.list_index][list_fill[it.list_index]] = it.value;
        list_fill[it.list_index]++;
      end
    end
    if (!it.end_of_load) return;

    total = 0;
    for (int k = 0; k < LIST_COUNT; k++) begin
      total += list_fill[k];
      read_pos[k] = 0;
    end
    r.overflow = list_overflowed;
    if (total == 0) begin
      r.merged_value = '0;
      r.last_of_run = 1'b1;
      r.nothing_loaded = 1'b1;
      merged_expect = {merged_expect, r};
    end else begin
      for (int n = 0; n < total; n++) begin
        best = -1;
        best_val = '0;
        for (int k = 0; k < LIST_COUNT; k++) begin
          if (read_pos[k] < list_fill[k]) begin
            if (best < 0 || list_data[k][read_pos[k]] < best_val) begin
              best = k;
              best_val = list_data[k][read_pos[k]];
            end
          end
        end
        read_pos[best]++;
        r.merged_value = best_val;
        r.last_of_run = (n + 1 == total);
        r.nothing_loaded = 1'b0;
        merged_expect = {merged_expect, r};
      end
    end
    for (int k = 0; k < LIST_COUNT; k++) list_fill[k] = 0;
    list_overflowed = 1'b0;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (merged_expect.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %p", $time, got);
      mismatch_count++;
      return;
    end
    want = merged_expect.pop_front();
    results_checked++;
    if (got.merged_value !== want.merged_value) begin
      $display("%0t: merged_value expected %0d, got %0d", $time, want.merged_value,
               got.merged_value);
      mismatch_count++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run,
               got.last_of_run);
      mismatch_count++;
    end
    if (got.nothing_loaded !== want.nothing_loaded) begin
      $display("%0t: nothing_loaded expected %b, got %b", $time, want.nothing_loaded,
               got.nothing_loaded);
      mismatch_count++;
    end
    if (got.overflow !== want.overflow) begin
      $display("%0t: overflow expected %b, got %b", $time, want.overflow, got.overflow);
      mismatch_count++;
    end
    if (want.last_of_run) runs_seen++;
    if (want.nothing_loaded) empty_runs++;
    if (want.overflow && want.last_of_run) overflow_runs++;
  endtask

  // Driver: inputs change on the falling edge. A held item stays put until the
  // transfer seen at the previous rising edge frees the channel.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if (!item_valid || item_taken) begin
        if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          item <= item_backlog.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: both channels are sampled on the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && item_ready;
      if (item_valid && item_ready) begin
        items_accepted++;
        absorb_item(item);
      end
      if (result_valid && result_ready) check_result(result);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still due", $time, merged_expect.size());
      $display("FAIL k_way_sorted_list_merge");
      $finish;
    end
  end

  task automatic queue_item(input logic [2:0] idx, input logic signed [31:0] val,
                            input bit carry, input bit eol);
    in_item_t it;
    it.list_index = idx;
    it.value = val;
    it.carries_value = carry;
    it.end_of_load = eol;
    item_backlog = {item_backlog, it};
    if (carry || eol) stim_items++;
  endtask

  task automatic queue_noise();
    queue_item(3'($urandom_range(0, 7)), $urandom(), 1'b0, 1'b0);
  endtask

  // Waits until every queued item is transferred and, if asked, every result is in.
  task automatic drain(input bit want_results);
    while (item_backlog.size() != 0 || item_valid) @(posedge clk);
    if (want_results) begin
      while (merged_expect.size() != 0) @(posedge clk);
    end
  endtask

  // One load followed by its end-of-load item. Most loads keep every list
  // ascending; some are narrow so equal heads compete, some unsorted, and a
  // few are long enough to fill lists and drop elements.
  task automatic random_run();
    int unsigned n;
    int unsigned pick;
    int unsigned shape;
    longint      tail[LIST_COUNT];
    longint      v;
    logic [2:0]  idx;
    bit          eol_carries;
    pick = $urandom_range(0, 99);
    if (pick < 8) n = 0;
    else if (pick < 88) n = $urandom_range(1, 12);
    else n = $urandom_range(30, 70);
    shape = $urandom_range(0, 9);
    eol_carries = 1'($urandom_range(0, 1));
    for (int k = 0; k < LIST_COUNT; k++) begin
      if (shape < 4) tail[k] = longint'($urandom_range(0, 10)) - 8;
      else if ($urandom_range(0, 7) == 0) tail[k] = longint'(INT_MIN);
      else tail[k] = longint'(int'($urandom()));
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) queue_noise();
      idx = 3'($urandom_range(0, LIST_COUNT - 1));
      if (shape >= 8) begin
        v = longint'(int'($urandom()));
      end else begin
        v = tail[idx] + ((shape < 4) ? $urandom_range(0, 2) : $urandom_range(0, 1 << 24));
        if (v > longint'(INT_MAX)) v = longint'(INT_MAX);
        tail[idx] = v;
      end
      queue_item(idx, v[31:0], 1'b1, (i == n - 1) && eol_carries);
    end
    if (n == 0 || !eol_carries) queue_item(3'($urandom_range(0, 7)), $urandom(), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned phase_goal;
    rst = 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 81;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An idle item, then an end of load with nothing stored.
    queue_item(3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_item(3'd0, 32'd0, 1'b0, 1'b1);
    // One element per list with the value extremes and equal heads; the
    // end-of-load item stores the last one itself.
    queue_item(3'd0, INT_MIN, 1'b1, 1'b0);
    queue_item(3'd1, INT_MAX, 1'b1, 1'b0);
    queue_item(3'd2, 32'sd0, 1'b1, 1'b0);
    queue_item(3'd3, -32'sd1, 1'b1, 1'b0);
    queue_item(3'd4, 32'sd0, 1'b1, 1'b0);
    queue_item(3'd5, 32'sd5, 1'b1, 1'b0);
    queue_item(3'd6, INT_MIN, 1'b1, 1'b0);
    queue_item(3'd7, 32'sd1, 1'b1, 1'b1);
    // A descending list pushed one past its depth, so one element is dropped.
    for (int i = 0; i <= LIST_DEPTH; i++) queue_item(3'd5, 32'sd80 - 10 * i, 1'b1, 1'b0);
    queue_item(3'd0, 32'sd35, 1'b1, 1'b0);
    queue_item(3'd2, 32'sd0, 1'b0, 1'b1);
    // The drop flag must be gone on the next run.
    queue_item(3'd2, -32'sd5, 1'b1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 81;
        recv_idle_pct = 34;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_goal = stim_items + ITEMS_PER_PHASE;
      while (stim_items < phase_goal) begin
        random_run();
        // Now and then the sender holds off until the merge has fully drained.
        if ($urandom_range(0, 7) == 0) drain(1'b1);
      end
      drain(1'b1);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d item transfers and %0d results in %0d merged runs,",
             items_accepted, results_checked, runs_seen);
    $display("of them %0d with nothing loaded and %0d with dropped elements.",
             empty_runs, overflow_runs);
    if (mismatch_count == 0 && merged_expect.size() == 0) begin
      $display("PASS k_way_sorted_list_merge");
    end else begin
      $display("FAIL k_way_sorted_list_merge");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/kwm_pkg.sv
src/kwm_ram.sv
src/kwm_front.sv
src/kwm_back.sv
src/k_way_sorted_list_merge.sv
bench/tb_k_way_sorted_list_merge.sv
